// ----- rtl/core/dlsp_pkg.sv -----
// ----------------------------------------------------------------------------
// dlsp_pkg
// Shared types, character codes and helpers for the decimal list sum parser.
// ----------------------------------------------------------------------------
package dlsp_pkg;

  localparam int WordWidth = 32;
  localparam int SumWidth  = 32;

  typedef logic [WordWidth-1:0] word_t;

  // Character codes.
  localparam logic [7:0] CharNul    = 8'h00;
  localparam logic [7:0] CharTab    = 8'h09;
  localparam logic [7:0] CharLf     = 8'h0A;
  localparam logic [7:0] CharVt     = 8'h0B;
  localparam logic [7:0] CharFf     = 8'h0C;
  localparam logic [7:0] CharCr     = 8'h0D;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharPlus   = 8'h2B;
  localparam logic [7:0] CharComma  = 8'h2C;
  localparam logic [7:0] CharMinus  = 8'h2D;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;
  localparam logic [7:0] CharEquals = 8'h3D;
  localparam logic [7:0] CharF      = 8'h46;
  localparam logic [7:0] CharI      = 8'h49;
  localparam logic [7:0] CharN      = 8'h4E;

  // Progress of the "FIN" match.
  localparam logic [2:0] FinStart   = 3'd0;
  localparam logic [2:0] FinMatched = 3'd3;
  localparam logic [2:0] FinNoMatch = 3'd4;

  typedef enum logic [2:0] {
    CMD_DIGIT,
    CMD_PLUS,
    CMD_MINUS,
    CMD_BLANK,
    CMD_OTHER,
    CMD_COMMA,
    CMD_TERM
  } cmd_kind_e;

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_SIGN,
    PH_DIGITS,
    PH_REST
  } phase_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [3:0]  digit;
    logic        fin;
  } cmd_t;

  function automatic logic [7:0] fin_char(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0:    ch = CharF;
      2'd1:    ch = CharI;
      default: ch = CharN;
    endcase
    return ch;
  endfunction

  // Sign-extend or truncate the wrapped sum to the output width.
  function automatic logic [SumWidth-1:0] to_out_sum(input word_t s);
    logic signed [WordWidth+SumWidth-1:0] ext;
    ext = (WordWidth+SumWidth)'(signed'(s));
    return ext[SumWidth-1:0];
  endfunction

endpackage

// ----- rtl/core/dlsp_front.sv -----
// ----------------------------------------------------------------------------
// dlsp_front
// Accepts bytes, tracks package framing and the "FIN" match, and turns each
// byte that matters into a command for the token engine.
// ----------------------------------------------------------------------------
module dlsp_front (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         byte_valid_i,
  output logic         byte_ready_o,
  input  logic [7:0]   byte_i,
  output logic         cmd_valid_o,
  input  logic         cmd_ready_i,
  output dlsp_pkg::cmd_t cmd_o
);
  import dlsp_pkg::*;

  logic       stopped_q, stopped_d;
  logic       swallow_q, swallow_d;
  logic       zero_seen_q, zero_seen_d;
  logic [2:0] fin_prog_q, fin_prog_d;
  logic       accept;
  logic       push;

  assign byte_ready_o = cmd_ready_i;
  assign accept       = byte_valid_i && cmd_ready_i;
  assign cmd_valid_o  = accept && push;

  always_comb begin
    stopped_d   = stopped_q;
    swallow_d   = swallow_q;
    zero_seen_d = zero_seen_q;
    fin_prog_d  = fin_prog_q;
    push        = 1'b0;
    cmd_o.kind  = CMD_OTHER;
    cmd_o.digit = byte_i[3:0];
    cmd_o.fin   = 1'b0;

    if (accept && !stopped_q) begin
      swallow_d = 1'b0;
      if (swallow_q && byte_i == CharLf) begin
        push = 1'b0;
      end else if (byte_i == CharEquals || byte_i == CharLf) begin
        push        = 1'b1;
        cmd_o.kind  = CMD_TERM;
        cmd_o.fin   = (fin_prog_q == FinMatched);
        stopped_d   = (fin_prog_q == FinMatched);
        fin_prog_d  = FinStart;
        zero_seen_d = 1'b0;
        swallow_d   = 1'b1;
      end else if (zero_seen_q) begin
        push = 1'b0;
      end else if (byte_i == CharNul) begin
        zero_seen_d = 1'b1;
      end else begin
        push = 1'b1;
        if (fin_prog_q < FinMatched && byte_i == fin_char(fin_prog_q[1:0])) begin
          fin_prog_d = fin_prog_q + 3'd1;
        end else begin
          fin_prog_d = FinNoMatch;
        end
        unique case (byte_i) inside
          [CharZero:CharNine]:                        cmd_o.kind = CMD_DIGIT;
          CharPlus:                                   cmd_o.kind = CMD_PLUS;
          CharMinus:                                  cmd_o.kind = CMD_MINUS;
          CharComma:                                  cmd_o.kind = CMD_COMMA;
          CharSpace, CharTab, CharVt, CharFf, CharCr: cmd_o.kind = CMD_BLANK;
          default:                                    cmd_o.kind = CMD_OTHER;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stopped_q   <= 1'b0;
      swallow_q   <= 1'b0;
      zero_seen_q <= 1'b0;
      fin_prog_q  <= FinStart;
    end else begin
      stopped_q   <= stopped_d;
      swallow_q   <= swallow_d;
      zero_seen_q <= zero_seen_d;
      fin_prog_q  <= fin_prog_d;
    end
  end

endmodule

// ----- rtl/core/dlsp_queue.sv -----
// ----------------------------------------------------------------------------
// dlsp_queue
// Two-entry command queue between the front end and the token engine.
// ----------------------------------------------------------------------------
module dlsp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           ready_o,
  input  dlsp_pkg::cmd_t cmd_i,
  output logic           valid_o,
  input  logic           pop_i,
  output dlsp_pkg::cmd_t cmd_o
);
  import dlsp_pkg::*;

  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign cmd_o   = entry_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ----- rtl/core/dlsp_back.sv -----
// ----------------------------------------------------------------------------
// dlsp_back
// Token engine: builds token values, accumulates the package sum and holds
// the result register toward the output stream.
// ----------------------------------------------------------------------------
module dlsp_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cmd_valid_i,
  output logic                           cmd_ready_o,
  input  dlsp_pkg::cmd_t                 cmd_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output logic [dlsp_pkg::SumWidth-1:0]  res_sum_o,
  output logic                           res_fin_o
);
  import dlsp_pkg::*;

  word_t                sum_q, sum_d;
  word_t                tok_q, tok_d;
  logic                 neg_q, neg_d;
  phase_e               phase_q, phase_d;
  logic                 out_valid_q, out_valid_d;
  logic [SumWidth-1:0]  out_sum_q, out_sum_d;
  logic                 out_fin_q, out_fin_d;
  logic                 out_free;
  logic                 take;
  word_t                tok_signed;
  word_t                sum_closed;
  word_t                tok_times_ten;

  assign out_free    = !out_valid_q || res_ready_i;
  assign cmd_ready_o = (cmd_i.kind != CMD_TERM) || out_free;
  assign take        = cmd_valid_i && cmd_ready_o;

  assign tok_signed    = neg_q ? (~tok_q + word_t'(1)) : tok_q;
  assign sum_closed    = sum_q + tok_signed;
  assign tok_times_ten = (tok_q << 3) + (tok_q << 1) + word_t'(cmd_i.digit);

  always_comb begin
    sum_d       = sum_q;
    tok_d       = tok_q;
    neg_d       = neg_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q && !res_ready_i;
    out_sum_d   = out_sum_q;
    out_fin_d   = out_fin_q;

    if (take) begin
      if (cmd_i.kind == CMD_COMMA || cmd_i.kind == CMD_TERM) begin
        sum_d   = sum_closed;
        tok_d   = '0;
        neg_d   = 1'b0;
        phase_d = PH_LEAD;
        if (cmd_i.kind == CMD_TERM) begin
          sum_d       = '0;
          out_valid_d = 1'b1;
          out_fin_d   = cmd_i.fin;
          out_sum_d   = cmd_i.fin ? '0 : to_out_sum(sum_closed);
        end
      end else if (phase_q == PH_LEAD && cmd_i.kind == CMD_BLANK) begin
        phase_d = PH_LEAD;
      end else if (phase_q == PH_LEAD &&
                   (cmd_i.kind == CMD_PLUS || cmd_i.kind == CMD_MINUS)) begin
        neg_d   = (cmd_i.kind == CMD_MINUS);
        phase_d = PH_SIGN;
      end else if (phase_q != PH_REST) begin
        if (cmd_i.kind == CMD_DIGIT) begin
          tok_d   = tok_times_ten;
          phase_d = PH_DIGITS;
        end else begin
          phase_d = PH_REST;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_sum_q <= out_sum_d;
    out_fin_q <= out_fin_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      tok_q       <= '0;
      neg_q       <= 1'b0;
      phase_q     <= PH_LEAD;
      out_valid_q <= 1'b0;
    end else begin
      sum_q       <= sum_d;
      tok_q       <= tok_d;
      neg_q       <= neg_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_sum_o   = out_sum_q;
  assign res_fin_o   = out_fin_q;

endmodule

// ----- rtl/core/decimal_list_sum_parser_unit.sv -----
// A terminator byte is written into the two-entry command queue, and the token engine
// then takes it from there and registers the package result in its output register.
// Throughput: one byte per cycle; the two-entry command queue absorbs a
// stalled result so the input keeps flowing until the queue fills.
// Reset (rst_ni low, asynchronous) clears the sum, token state, the "FIN"
// match and the stop flag; after a "FIN" package all bytes are dropped.
// ----------------------------------------------------------------------------
// decimal_list_sum_parser_unit
// Parses comma-separated decimal tokens from an ASCII byte stream and emits
// the wrapped sum of each package at its terminator.
// ----------------------------------------------------------------------------
module decimal_list_sum_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] text_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] package_sum
  output logic        m_axis_tuser_o    // [0] finished
);
  import dlsp_pkg::*;

  cmd_t front_cmd;
  cmd_t queue_cmd;
  logic front_valid;
  logic queue_ready;
  logic queue_valid;
  logic back_ready;

  dlsp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid_i),
    .byte_ready_o (s_axis_tready_o),
    .byte_i       (s_axis_tdata_i),
    .cmd_valid_o  (front_valid),
    .cmd_ready_i  (queue_ready),
    .cmd_o        (front_cmd)
  );

  dlsp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .ready_o (queue_ready),
    .cmd_i   (front_cmd),
    .valid_o (queue_valid),
    .pop_i   (back_ready),
    .cmd_o   (queue_cmd)
  );

  dlsp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (queue_valid),
    .cmd_ready_o (back_ready),
    .cmd_i       (queue_cmd),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .res_sum_o   (m_axis_tdata_o),
    .res_fin_o   (m_axis_tuser_o)
  );

endmodule

// ----- rtl/core/dlsp_checker.sv -----
// ----------------------------------------------------------------------------
// dlsp_checker
// Port-level checks on the output stream of the parser, bound to the top.
// ----------------------------------------------------------------------------
module dlsp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o
);

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result valid dropped while stalled");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result payload changed while stalled");

  // A finished package always reports a zero sum.
  a_fin_zero_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == 32'd0)
    else $error("finished result with nonzero sum");

  // Nothing follows a finished transaction until reset.
  a_silent_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && m_axis_tuser_o |=> !m_axis_tvalid_o)
    else $error("result after finished transaction");

endmodule

bind decimal_list_sum_parser_unit dlsp_checker u_dlsp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Streams ASCII bytes into the decimal list sum parser and checks every
// package sum against a cycle-free prediction of the parser. The stimulus
// covers blanks, signs, wrapping tokens, zero bytes, near and exact "FIN"
// packages, and swallowed newlines. Both stream sides throttle at random.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dlsp_pkg::*;

  localparam int StallLimit  = 2000;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 6;
  localparam int PhaseBytes  = 110;
  localparam int MaxPrinted  = 30;

  typedef enum int {
    IdleNone,
    IdleLight,
    IdleHeavy
  } idle_mode_e;

  typedef struct packed {
    logic [SumWidth-1:0] sum;
    logic                fin;
  } package_result_t;

  // Tracks the parser state and holds the package results still to come.
  class sum_scoreboard;
    word_t           running_sum;
    word_t           token_value;
    bit              token_negative;
    phase_e          token_phase;
    logic [2:0]      fin_progress;
    bit              zero_seen;
    bit              swallow_lf;
    bit              stopped;
    package_result_t expected_q[$];
    int              error_count;

    function new();
      running_sum    = '0;
      token_value    = '0;
      token_negative = 1'b0;
      token_phase    = PH_LEAD;
      fin_progress   = FinStart;
      zero_seen      = 1'b0;
      swallow_lf     = 1'b0;
      stopped        = 1'b0;
      error_count    = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void restart_token();
      token_value    = '0;
      token_negative = 1'b0;
      token_phase    = PH_LEAD;
    endfunction

    function void add_token();
      word_t v;
      v = token_negative ? word_t'(-token_value) : token_value;
      running_sum = running_sum + v;
      restart_token();
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == CharSpace || c == CharTab || c == CharVt || c == CharFf || c == CharCr;
    endfunction

    function void track_fin(logic [7:0] c);
      logic [7:0] want;
      case (fin_progress)
        FinStart:        want = CharF;
        FinStart + 3'd1: want = CharI;
        default:         want = CharN;
      endcase
      if (fin_progress < FinMatched && c == want) begin
        fin_progress = fin_progress + 3'd1;
      end else begin
        fin_progress = FinNoMatch;
      end
    endfunction

    function void parse_char(logic [7:0] c);
      if (c == CharComma) begin
        add_token();
        return;
      end
      if (token_phase == PH_LEAD) begin
        if (is_blank(c)) return;
        if (c == CharPlus || c == CharMinus) begin
          token_negative = (c == CharMinus);
          token_phase    = PH_SIGN;
          return;
        end
      end
      if (token_phase != PH_REST) begin
        if (c >= CharZero && c <= CharNine) begin
          token_value = token_value * 10 + word_t'(c - CharZero);
          token_phase = PH_DIGITS;
        end else begin
          token_phase = PH_REST;
        end
      end
    endfunction

    // Called for every accepted byte; queues a result at each terminator until "FIN" stops the stream.
    function void note_byte(logic [7:0] c);
      package_result_t r;
      if (stopped) return;
      if (swallow_lf) begin
        swallow_lf = 1'b0;
        if (c == CharLf) return;
      end
      if (c == CharEquals || c == CharLf) begin
        add_token();
        if (fin_progress == FinMatched) begin
          r.sum   = '0;
          r.fin   = 1'b1;
          stopped = 1'b1;
        end else begin
          r.sum = SumWidth'($signed(running_sum));
          r.fin = 1'b0;
        end
        expected_q.push_back(r);
        running_sum  = '0;
        restart_token();
        fin_progress = FinStart;
        zero_seen    = 1'b0;
        swallow_lf   = 1'b1;
        return;
      end
      if (zero_seen) return;
      if (c == CharNul) begin
        zero_seen = 1'b1;
        return;
      end
      track_fin(c);
      parse_char(c);
    endfunction

    task report(string what);
      if (error_count < MaxPrinted) $display("%0t mismatch: %s", $time, what);
      error_count++;
    endtask

    task check_result(logic [SumWidth-1:0] sum, logic fin);
      package_result_t exp_r;
      if (expected_q.size() == 0) begin
        report($sformatf("result sum %0d finished %b with none expected", $signed(sum), fin));
        return;
      end
      exp_r = expected_q.pop_front();
      if (sum !== exp_r.sum) begin
        report($sformatf("package sum %0d, expected %0d", $signed(sum), $signed(exp_r.sum)));
      end
      if (fin !== exp_r.fin) begin
        report($sformatf("finished flag %b, expected %b", fin, exp_r.fin));
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        s_valid;
  logic [7:0]  s_data;
  logic        s_ready;
  logic        m_valid;
  logic        m_ready;
  logic [31:0] m_data;
  logic        m_user;

  sum_scoreboard sb = new();

  idle_mode_e tx_mode;
  idle_mode_e rx_mode;
  bit         hold_req;
  int         burst_left;
  int         bytes_sent;
  int         idle_cycles = 0;

  decimal_list_sum_parser_unit DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: always ready, stalls on a rotating random mask or at random, by mode, or holds off for a long
  // stretch once on request so that the parser backs up into its input.
  initial begin
    logic [15:0] stall_mask;
    int          mask_pos;
    bit          hold_seen;
    stall_mask = 16'hFFFF;
    mask_pos   = 0;
    hold_seen  = 1'b0;
    m_ready    = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_seen) begin
        hold_seen = 1'b1;
        m_ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end
      case (rx_mode)
        IdleNone: m_ready <= 1'b1;
        IdleLight: begin
          if (mask_pos == 0) stall_mask = 16'($urandom) | 16'($urandom);
          m_ready <= stall_mask[mask_pos];
          mask_pos = (mask_pos + 1) % 16;
        end
        default: m_ready <= ($urandom_range(0, 2) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && m_valid && m_ready) sb.check_result(m_data, m_user);
  end

  always @(posedge clk) begin
    if ((s_valid && s_ready) || (m_valid && m_ready) || !rst_n) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("[decimal_list_sum_parser_unit] ERROR");
        $finish;
      end
    end
  end

  // Offers one byte in bursts whose length and gaps depend on the send mode, and waits for its transaction.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      case (tx_mode)
        IdleNone: begin
          gap        = 0;
          burst_left = 64;
        end
        IdleLight: begin
          gap        = $urandom_range(0, 5);
          burst_left = $urandom_range(1, 8);
        end
        default: begin
          gap        = $urandom_range(1, 12);
          burst_left = $urandom_range(1, 3);
        end
      endcase
      if (gap > 0) begin
        s_valid <= 1'b0;
        s_data  <= 8'($urandom);
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_valid <= 1'b1;
    s_data  <= b;
    do @(posedge clk); while (!s_ready);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_text(input string txt);
    for (int i = 0; i < txt.len(); i++) send_byte(txt[i]);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    s_valid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 4))
      0:       return CharSpace;
      1:       return CharTab;
      2:       return CharVt;
      3:       return CharFf;
      default: return CharCr;
    endcase
  endfunction

  // Junk never carries an 'F', so no random package can spell the stop word.
  function automatic logic [7:0] pick_junk();
    logic [7:0] j;
    j = 8'($urandom_range(8'h21, 8'h7E));
    return (j == CharF) ? CharSpace : j;
  endfunction

  task automatic send_token();
    repeat ($urandom_range(0, 2)) send_byte(pick_blank());
    case ($urandom_range(0, 2))
      0:       send_byte(CharPlus);
      1:       send_byte(CharMinus);
      default: ;
    endcase
    if ($urandom_range(0, 15) == 0) send_byte(CharSpace);
    case ($urandom_range(0, 9))
      0:       ;
      1:       send_text($sformatf("%0d", $urandom));
      2:       repeat ($urandom_range(11, 20)) send_byte(CharZero + 8'($urandom_range(0, 9)));
      default: repeat ($urandom_range(1, 5)) send_byte(CharZero + 8'($urandom_range(0, 9)));
    endcase
    if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 3)) send_byte(pick_junk());
    if ($urandom_range(0, 24) == 0) send_byte(CharNul);
  endtask

  task automatic send_package();
    logic [7:0] b;
    case ($urandom_range(0, 11))
      0, 1: begin
        repeat ($urandom_range(1, 8)) begin
          b = 8'($urandom);
          send_byte((b == CharF) ? CharComma : b);
        end
      end
      2: begin
        case ($urandom_range(0, 4))
          0: send_text("FI");
          1: send_text("FINN");
          2: send_text("fin");
          3: send_text(" FIN");
          default: begin
            send_text("FI");
            send_byte(CharNul);
            send_text("N");
          end
        endcase
      end
      default: begin
        send_token();
        repeat ($urandom_range(0, 3)) begin
          send_byte(CharComma);
          send_token();
        end
      end
    endcase
    send_byte($urandom_range(0, 1) ? CharEquals : CharLf);
    if ($urandom_range(0, 2) == 0) send_byte(CharLf);
  endtask

  initial begin
    int phase_idx;
    int phase_end;
    phase_idx   = 0;
    hold_req    = 1'b0;
    burst_left  = 0;
    bytes_sent  = 0;
    tx_mode     = IdleLight;
    rx_mode     = IdleLight;
    rst_n       = 1'b0;
    s_valid     = 1'b0;
    s_data      = 8'h00;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Signs, trailing junk, empty tokens and a swallowed newline.
    send_text("\t-12a,,+7=");
    send_byte(CharLf);
    // Vertical tab, form feed and carriage return blanks, then a zero byte that hides the rest of the package.
    send_byte(CharVt);
    send_byte(CharFf);
    send_byte(CharCr);
    send_text(" 9");
    send_byte(CharNul);
    send_text("x5");
    send_byte(CharLf);
    // A terminator right after a terminator is an empty package.
    send_byte(CharEquals);
    send_byte(8'hFF);
    send_byte(CharEquals);
    // A zero byte inside the stop word breaks the match.
    send_text("F");
    send_byte(CharNul);
    send_text("IN=");
    wait_for_results();

    while (bytes_sent < 700) begin
      case (phase_idx % 4)
        0: begin
          tx_mode = IdleNone;
          rx_mode = IdleNone;
        end
        1: begin
          tx_mode  = IdleNone;
          rx_mode  = IdleLight;
          hold_req = 1'b1;
        end
        2: begin
          tx_mode = IdleLight;
          rx_mode = IdleLight;
        end
        default: begin
          tx_mode = IdleHeavy;
          rx_mode = IdleHeavy;
        end
      endcase
      burst_left = 0;
      phase_end  = bytes_sent + PhaseBytes;
      while (bytes_sent < phase_end) send_package();
      if (phase_idx % 4 == 3) wait_for_results();
      phase_idx++;
    end

    // The stop word ends the stream; its zero byte hides the trailing digit,
    // and everything after it must be dropped.
    tx_mode = IdleLight;
    rx_mode = IdleLight;
    send_text("FIN");
    send_byte(CharNul);
    send_text("9=");
    send_text("7,=");
    send_byte(CharLf);
    send_byte(CharEquals);
    wait_for_results();
    repeat (10) @(posedge clk);

    if (sb.error_count == 0) begin
      $display("[decimal_list_sum_parser_unit] OK");
    end else begin
      $display("[decimal_list_sum_parser_unit] ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/dlsp_pkg.sv
rtl/core/dlsp_front.sv
rtl/core/dlsp_queue.sv
rtl/core/dlsp_back.sv
rtl/core/decimal_list_sum_parser_unit.sv
rtl/core/dlsp_checker.sv
test/tb_top.sv
